>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Short forms for clocked implication checks, disabled while reset is high.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/obar_pkg.sv
// ---------------------------------------------------------------------------
// OHLC bar aggregator package
// Field widths, item types and shared constants.
// ---------------------------------------------------------------------------
`default_nettype none

package obar_pkg;

  localparam int DAY_W   = 20;
  localparam int TIME_W  = 27;
  localparam int PRICE_W = 32;
  localparam int VIN_W   = 32;
  localparam int VOL_W   = 48;
  localparam int IDX_W   = 32;

  // One day in milliseconds, and the reset bar length
  localparam logic [TIME_W-1:0] DAY_MS       = 27'd86400000;
  localparam logic [TIME_W-1:0] PERIOD_RESET = 27'd60000;

  localparam int QUEUE_DEPTH_DEFAULT = 2;

  typedef struct packed {
    logic [DAY_W-1:0]   day_number;
    logic [TIME_W-1:0]  time_of_day_ms;
    logic [PRICE_W-1:0] open_price;
    logic [PRICE_W-1:0] high_price;
    logic [PRICE_W-1:0] low_price;
    logic [PRICE_W-1:0] close_price;
    logic [VIN_W-1:0]   trade_volume;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]   bar_index;
    logic [DAY_W-1:0]   bar_day;
    logic [TIME_W-1:0]  bar_start_ms;
    logic [PRICE_W-1:0] bar_open;
    logic [PRICE_W-1:0] bar_high;
    logic [PRICE_W-1:0] bar_low;
    logic [PRICE_W-1:0] bar_close;
    logic [VOL_W-1:0]   bar_volume;
    logic               started_new;
  } out_item_t;

  // Queue entry: the item plus its aligned period start
  typedef struct packed {
    in_item_t          item;
    logic [TIME_W-1:0] start_ms;
  } q_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

`default_nettype wire

>>> rtl/obar_front.sv
// ---------------------------------------------------------------------------
// OHLC bar front end
// Accepts an item and finds the aligned period start with a bit-serial
// remainder unit, then pushes item and start into the queue.
// ---------------------------------------------------------------------------
`default_nettype none

module obar_front
  import obar_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire in_item_t          in_data,
  input  wire logic [TIME_W-1:0] period,
  input  wire logic              q_full,
  output logic                   push,
  output q_item_t                push_data
);

  localparam int CNT_W = $clog2(TIME_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TIME_W - 1);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_DIV  = 3'b010,
    F_PUSH = 3'b100
  } front_state_t;

  front_state_t      state;
  in_item_t          item;
  logic [TIME_W-1:0] dividend;
  logic [TIME_W-1:0] rem;
  logic [CNT_W-1:0]  cnt;

  logic [TIME_W:0]   trial;
  logic              trial_ge;
  logic [TIME_W-1:0] rem_next;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial    = {rem, dividend[TIME_W-1]};
    trial_ge = (trial >= {1'b0, period});
    rem_next = trial_ge ? TIME_W'(trial - {1'b0, period}) : trial[TIME_W-1:0];
  end

  // Advance the sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (in_valid) state <= F_DIV;
        end
        F_DIV: begin
          if (cnt == CNT_LAST) state <= F_PUSH;
        end
        F_PUSH: begin
          if (!q_full) state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  // Hold the item and run the remainder datapath
  always_ff @(posedge clk) begin
    if (state == F_IDLE) begin
      item     <= in_data;
      dividend <= in_data.time_of_day_ms;
      rem      <= '0;
      cnt      <= '0;
    end else if (state == F_DIV) begin
      rem      <= rem_next;
      dividend <= {dividend[TIME_W-2:0], 1'b0};
      cnt      <= cnt + 1'b1;
    end
  end

  assign in_ready = (state == F_IDLE) && !rst;
  assign push     = (state == F_PUSH) && !q_full;

  // Period start is the time with its remainder dropped
  always_comb begin
    push_data.item     = item;
    push_data.start_ms = item.time_of_day_ms - rem;
  end

endmodule

`default_nettype wire

>>> rtl/obar_queue.sv
// ---------------------------------------------------------------------------
// OHLC bar queue
// Short FIFO between front end and merge stage.
// ---------------------------------------------------------------------------
`default_nettype none

module obar_queue
  import obar_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire q_item_t push_data,
  input  wire logic    pop,
  output q_item_t      pop_data,
  output q_status_t    status
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  q_item_t          entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  // Write the entry at the tail
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  assign pop_data     = entries[rd_ptr];
  assign status.full  = (count == CNT_FULL);
  assign status.empty = (count == '0);

endmodule

`default_nettype wire

>>> rtl/obar_back.sv
// ---------------------------------------------------------------------------
// OHLC bar merge stage
// Tests whether an item falls in the current bar, merges or opens a bar,
// and registers the result for the output channel.
// ---------------------------------------------------------------------------
`default_nettype none

module obar_back
  import obar_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [TIME_W-1:0] period,
  input  wire logic              q_empty,
  output logic                   pop,
  input  wire q_item_t           pop_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output out_item_t              out_data
);

  localparam int DIFF_W = DAY_W + 1;
  localparam int BASE_W = TIME_W + 2;
  localparam int REL_W  = TIME_W + 5;

  localparam logic [DIFF_W-1:0] DIFF_SAME  = '0;
  localparam logic [DIFF_W-1:0] DIFF_NEXT  = DIFF_W'(1);
  localparam logic [DIFF_W-1:0] DIFF_NEXT2 = DIFF_W'(2);
  localparam logic [DIFF_W-1:0] DIFF_PREV  = '1;

  localparam logic [REL_W-1:0] OFS_DAY  = REL_W'(DAY_MS);
  localparam logic [REL_W-1:0] OFS_DAY2 = REL_W'({DAY_MS, 1'b0});

  // Current bar
  logic               present;
  logic [IDX_W-1:0]   cur_index;
  logic [DAY_W-1:0]   cur_day;
  logic [TIME_W-1:0]  cur_start;
  logic [PRICE_W-1:0] cur_open;
  logic [PRICE_W-1:0] cur_high;
  logic [PRICE_W-1:0] cur_low;
  logic [PRICE_W-1:0] cur_close;
  logic [VOL_W-1:0]   cur_volume;

  in_item_t           it;
  logic [DIFF_W-1:0]  day_diff;
  logic [BASE_W-1:0]  base;
  logic [REL_W-1:0]   offset;
  logic               day_ok;
  logic [REL_W-1:0]   rel;
  logic               in_bar;
  logic [VOL_W:0]     vol_sum;
  out_item_t          result;

  assign pop = !q_empty && (!out_valid || out_ready);
  assign it  = pop_data.item;

  // Containment: only day distances of -1..2 can land in_bar a period
  always_comb begin
    day_diff = {1'b0, it.day_number} - {1'b0, cur_day};
    base     = {2'b00, it.time_of_day_ms} - {2'b00, cur_start};
    offset   = '0;
    day_ok   = 1'b1;
    unique case (day_diff)
      DIFF_SAME:  offset = '0;
      DIFF_NEXT:  offset = OFS_DAY;
      DIFF_NEXT2: offset = OFS_DAY2;
      DIFF_PREV:  offset = -OFS_DAY;
      default:    day_ok = 1'b0;
    endcase
    rel    = {{(REL_W - BASE_W){base[BASE_W-1]}}, base} + offset;
    in_bar = present && day_ok && !rel[REL_W-1]
             && (rel[REL_W-2:0] < (REL_W-1)'(period));
  end

  // Merge into the current bar or open a new one
  always_comb begin
    vol_sum = {1'b0, cur_volume} + (VOL_W+1)'(it.trade_volume);
    if (in_bar) begin
      result.bar_index    = cur_index;
      result.bar_day      = cur_day;
      result.bar_start_ms = cur_start;
      result.bar_open     = cur_open;
      result.bar_high     = (it.high_price > cur_high) ? it.high_price : cur_high;
      result.bar_low      = (it.low_price < cur_low) ? it.low_price : cur_low;
      result.bar_close    = it.close_price;
      result.bar_volume   = vol_sum[VOL_W] ? '1 : vol_sum[VOL_W-1:0];
      result.started_new  = 1'b0;
    end else begin
      result.bar_index    = present ? cur_index + 1'b1 : '0;
      result.bar_day      = it.day_number;
      result.bar_start_ms = pop_data.start_ms;
      result.bar_open     = it.open_price;
      result.bar_high     = it.high_price;
      result.bar_low      = it.low_price;
      result.bar_close    = it.close_price;
      result.bar_volume   = VOL_W'(it.trade_volume);
      result.started_new  = 1'b1;
    end
  end

  // Control: bar presence and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      present   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        present   <= 1'b1;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Update bar state and the output register
  always_ff @(posedge clk) begin
    if (pop) begin
      cur_index  <= result.bar_index;
      cur_day    <= result.bar_day;
      cur_start  <= result.bar_start_ms;
      cur_open   <= result.bar_open;
      cur_high   <= result.bar_high;
      cur_low    <= result.bar_low;
      cur_close  <= result.bar_close;
      cur_volume <= result.bar_volume;
      out_data   <= result;
    end
  end

endmodule

`default_nettype wire

>>> rtl/ohlc_bar_aggregator.sv
// OHLC bar aggregator: merges atomic OHLCV bars into midnight-aligned bars.
// The front end takes one item at a time: it accepts, runs its 27-step
// bit-serial remainder unit, then pushes, and waits while the queue is full.
// Path of an item: accept, remainder steps, push into the queue, merge and
// register in the output stage. Synchronous rst clears all control state, sets
// the bar length back to 60000 ms and forgets the current bar.
// ---------------------------------------------------------------------------
// OHLC bar aggregator top level
// Period register, front end, queue and merge stage.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ohlc_bar_aggregator
  import obar_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire in_item_t          in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output out_item_t              out_data,
  input  wire logic              cfg_we,
  input  wire logic [TIME_W-1:0] cfg_data
);

  logic [TIME_W-1:0] period;
  logic [TIME_W-1:0] period_next;
  logic              q_push;
  q_item_t           q_push_data;
  logic              q_pop;
  q_item_t           q_pop_data;
  q_status_t         q_stat;

  // Clamp the bar length to one millisecond up to one day
  always_comb begin
    priority if (cfg_data == '0) period_next = TIME_W'(1);
    else if (cfg_data > DAY_MS)  period_next = DAY_MS;
    else                         period_next = cfg_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      period <= PERIOD_RESET;
    end else if (cfg_we) begin
      period <= period_next;
    end
  end

  obar_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .period    (period),
    .q_full    (q_stat.full),
    .push      (q_push),
    .push_data (q_push_data)
  );

  obar_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .status    (q_stat)
  );

  obar_back u_back (
    .clk       (clk),
    .rst       (rst),
    .period    (period),
    .q_empty   (q_stat.empty),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Queue never overflows or underflows; front end is busy after an accept
  `ASSERT_IMPL(a_push_room, clk, rst, q_push, !q_stat.full)
  `ASSERT_IMPL(a_pop_data, clk, rst, q_pop, !q_stat.empty)
  `ASSERT_NEXT(a_front_busy, clk, rst, in_valid && in_ready, !in_ready)

endmodule

`default_nettype wire

>>> tb/sv/tb_ohlc_bar_aggregator.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// OHLC bar aggregator testbench
// Streams atomic bars through the aggregator under several bar lengths,
// predicts every merged bar and checks each result field by field.
// ---------------------------------------------------------------------------

// Running copy of the aggregated bar and the queue of bars still to come out
class bar_scoreboard;
  logic [obar_pkg::TIME_W-1:0]  period;
  bit                           open_bar;
  logic [obar_pkg::IDX_W-1:0]   idx;
  logic [obar_pkg::DAY_W-1:0]   day;
  logic [obar_pkg::TIME_W-1:0]  bar_start;
  logic [obar_pkg::PRICE_W-1:0] op, hi, lo, cl;
  logic [obar_pkg::VOL_W-1:0]   vol;
  obar_pkg::out_item_t          pending[$];
  int                           errors;
  int                           seen;

  function new();
    period    = obar_pkg::PERIOD_RESET;
    open_bar  = 1'b0;
    idx       = '0;
    day       = '0;
    bar_start = '0;
    op        = '0;
    hi        = '0;
    lo        = '0;
    cl        = '0;
    vol       = '0;
    errors    = 0;
    seen      = 0;
  endfunction

  // Bar length as the block uses it: zero acts as 1 ms, clamp to one day
  function longint bar_len();
    if (period == '0) return 1;
    if (period > obar_pkg::DAY_MS) return longint'(obar_pkg::DAY_MS);
    return longint'(period);
  endfunction

  // Merge one accepted item into the running bar and queue the expected result
  function void note_bar(obar_pkg::in_item_t it);
    longint                   len;
    longint                   rel;
    longint                   aligned;
    bit                       hit;
    logic [obar_pkg::VOL_W:0] sum;
    obar_pkg::out_item_t      e;
    len = bar_len();
    hit = 1'b0;
    if (open_bar) begin
      rel = (longint'(it.day_number) - longint'(day)) * longint'(obar_pkg::DAY_MS)
          + longint'(it.time_of_day_ms) - longint'(bar_start);
      hit = (rel >= 0) && (rel < len);
    end
    if (hit) begin
      cl  = it.close_price;
      sum = {1'b0, vol} + {17'b0, it.trade_volume};
      vol = sum[obar_pkg::VOL_W] ? '1 : sum[obar_pkg::VOL_W-1:0];
      if (it.high_price > hi) hi = it.high_price;
      if (it.low_price < lo) lo = it.low_price;
    end else begin
      idx       = open_bar ? idx + 32'd1 : '0;
      day       = it.day_number;
      aligned   = (longint'(it.time_of_day_ms) / len) * len;
      bar_start = aligned[obar_pkg::TIME_W-1:0];
      op        = it.open_price;
      hi        = it.high_price;
      lo        = it.low_price;
      cl        = it.close_price;
      vol       = {16'b0, it.trade_volume};
      open_bar  = 1'b1;
    end
    e.bar_index    = idx;
    e.bar_day      = day;
    e.bar_start_ms = bar_start;
    e.bar_open     = op;
    e.bar_high     = hi;
    e.bar_low      = lo;
    e.bar_close    = cl;
    e.bar_volume   = vol;
    e.started_new  = !hit;
    pending.push_back(e);
  endfunction

  function void flag(string msg);
    errors++;
    if (errors <= 10) $display("MISMATCH %s", msg);
  endfunction

  function void field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want)
      flag($sformatf("result %0d %s: expected %h, got %h", seen, name, want, got));
  endfunction

  // Compare one result with the oldest expected bar
  function void check_bar(obar_pkg::out_item_t got);
    obar_pkg::out_item_t e;
    seen++;
    if (pending.size() == 0) begin
      flag($sformatf("result %0d arrived with nothing expected", seen));
      return;
    end
    e = pending.pop_front();
    field("bar_index", e.bar_index, got.bar_index);
    field("bar_day", e.bar_day, got.bar_day);
    field("bar_start_ms", e.bar_start_ms, got.bar_start_ms);
    field("bar_open", e.bar_open, got.bar_open);
    field("bar_high", e.bar_high, got.bar_high);
    field("bar_low", e.bar_low, got.bar_low);
    field("bar_close", e.bar_close, got.bar_close);
    field("bar_volume", e.bar_volume, got.bar_volume);
    field("started_new", e.started_new, got.started_new);
  endfunction
endclass

module tb_ohlc_bar_aggregator;
  import obar_pkg::*;

  localparam longint      DAY_LEN     = 86400000;
  localparam int unsigned CYCLE_LIMIT = 1000000;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  in_item_t          in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_item_t         out_data;
  logic              cfg_we = 1'b0;
  logic [TIME_W-1:0] cfg_data = '0;

  bar_scoreboard     sb = new();
  bit                calm = 1'b0;
  int unsigned       cycles = 0;
  int unsigned       stall_left = 0;
  logic [DAY_W-1:0]  sim_day = '0;
  longint            sim_ms = 0;

  ohlc_bar_aggregator uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_ohlc_bar_aggregator failed");
      $finish;
    end
  end

  // Stall the result side at random, except in calm stretches
  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if (!calm && $urandom_range(0, 99) < 15)
        stall_left <= ($urandom_range(0, 99) < 85) ? $urandom_range(1, 35)
                                                   : $urandom_range(40, 120);
    end
  end

  // Check every result taken
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_bar(out_data);
  end

  // Offer one item and hold it until taken; returns at the next falling edge
  task automatic send_bar(in_item_t it);
    in_data  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_bar(it);
    @(negedge clk);
  endtask

  task automatic sender_gap();
    int unsigned r;
    int unsigned n;
    n = 0;
    if (!calm) begin
      r = $urandom_range(0, 99);
      if (r < 50) n = 0;
      else if (r < 92) n = $urandom_range(1, 35);
      else n = $urandom_range(40, 100);
    end
    if (n != 0) begin
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  // Hold off the sender until every expected bar is out, then let it go quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_len(logic [TIME_W-1:0] len);
    cfg_data <= len;
    cfg_we   <= 1'b1;
    @(negedge clk);
    cfg_we   <= 1'b0;
    sb.period = len;
  endtask

  task automatic push_bar(logic [DAY_W-1:0] d, logic [TIME_W-1:0] t,
                          logic [31:0] o, logic [31:0] h, logic [31:0] l,
                          logic [31:0] c, logic [31:0] v);
    in_item_t it;
    it.day_number     = d;
    it.time_of_day_ms = t;
    it.open_price     = o;
    it.high_price     = h;
    it.low_price      = l;
    it.close_price    = c;
    it.trade_volume   = v;
    send_bar(it);
    sender_gap();
  endtask

  function automatic logic [PRICE_W-1:0] rand_px();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom();
  endfunction

  // Advance the market clock: mostly small steps inside the bar, sometimes
  // skips, steps back, runs up to midnight, jumps or out-of-range times
  task automatic next_instant(output logic [DAY_W-1:0] d, output logic [TIME_W-1:0] t);
    longint      len;
    longint      step;
    int unsigned r;
    int unsigned rnd;
    bit          odd_time;
    len      = sb.bar_len();
    step     = 0;
    odd_time = 1'b0;
    r        = $urandom_range(0, 99);
    if (r < 65) begin
      step = $urandom_range(0, 32'(len / 4));
    end else if (r < 75) begin
      step = len + $urandom_range(0, 32'(2 * len));
    end else if (r < 80) begin
      step = -longint'($urandom_range(1, 32'(len)));
    end else if (r < 87) begin
      sim_ms = DAY_LEN - longint'($urandom_range(1, 32'(len)));
    end else if (r < 93) begin
      rnd     = $urandom();
      sim_day = rnd[DAY_W-1:0];
      sim_ms  = $urandom_range(0, 32'(DAY_LEN - 1));
    end else if (r < 97) begin
      odd_time = 1'b1;
    end
    sim_ms = sim_ms + step;
    while (sim_ms >= DAY_LEN) begin
      sim_ms  = sim_ms - DAY_LEN;
      sim_day = sim_day + 1'b1;
    end
    while (sim_ms < 0) begin
      sim_ms  = sim_ms + DAY_LEN;
      sim_day = sim_day - 1'b1;
    end
    d = sim_day;
    if (odd_time) begin
      rnd = $urandom_range(32'(DAY_LEN), 32'h07FF_FFFF);
      t   = rnd[TIME_W-1:0];
    end else begin
      t = sim_ms[TIME_W-1:0];
    end
  endtask

  task automatic random_bars(int n);
    in_item_t it;
    for (int k = 0; k < n; k++) begin
      next_instant(it.day_number, it.time_of_day_ms);
      it.open_price   = rand_px();
      it.high_price   = rand_px();
      it.low_price    = rand_px();
      it.close_price  = rand_px();
      it.trade_volume = ($urandom_range(0, 9) == 0) ? 32'hFFFF_FFFF : $urandom();
      send_bar(it);
      if ($urandom_range(0, 199) == 0) settle();
      else sender_gap();
    end
  endtask

  initial begin
    logic [TIME_W-1:0] lens [8];
    int unsigned       rnd;
    rnd  = $urandom_range(2, 32'h07FF_FFFF);
    lens = '{27'd0, 27'd1, DAY_MS, 27'h7FF_FFFF, 27'd7000000, 27'd1000, 27'd60000,
             rnd[TIME_W-1:0]};

    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // First bar after reset, merges at the edges of a one-minute bar
    push_bar(20'd0, 27'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    push_bar(20'd0, 27'd0, 32'd5, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_bar(20'd0, 27'd59999, 32'd1, 32'd2, 32'd3, 32'd4, 32'hFFFF_FFFF);
    push_bar(20'd0, 27'd60000, 32'd100, 32'd200, 32'd50, 32'd150, 32'd7);
    push_bar(20'd0, 27'd60001, 32'd0, 32'd150, 32'd60, 32'd120, 32'd1);
    push_bar(20'd0, 27'd60002, 32'd0, 32'd300, 32'd10, 32'd99, 32'd1);
    // Instant before the current bar, next day, last day, day wrap
    push_bar(20'd0, 27'd59999, 32'd9, 32'd9, 32'd9, 32'd9, 32'd9);
    push_bar(20'd1, 27'd0, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1);
    push_bar(20'hF_FFFF, DAY_MS - 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd7,
             32'd3);
    push_bar(20'd0, 27'd5, 32'd2, 32'd2, 32'd2, 32'd2, 32'd2);
    // Time of day past midnight's range
    push_bar(20'd5, 27'h7FF_FFFF, 32'd4, 32'd8, 32'd2, 32'd6, 32'd10);
    push_bar(20'd5, 27'h7FF_FFF5, 32'd4, 32'd9, 32'd1, 32'd5, 32'd10);
    push_bar(20'd6, 27'd0, 32'd3, 32'd3, 32'd3, 32'd3, 32'd3);

    // Bar that runs past midnight into the next day
    settle();
    write_len(27'd7000000);
    push_bar(20'd10, 27'd84000000, 32'd10, 32'd20, 32'd5, 32'd15, 32'd100);
    push_bar(20'd11, 27'd4000000, 32'd0, 32'd25, 32'd6, 32'd16, 32'd100);
    push_bar(20'd11, 27'd4599999, 32'd0, 32'd19, 32'd4, 32'd17, 32'd100);
    push_bar(20'd11, 27'd4600000, 32'd11, 32'd21, 32'd7, 32'd18, 32'd100);
    push_bar(20'd11, 27'd6999999, 32'd0, 32'd22, 32'd3, 32'd19, 32'd100);
    push_bar(20'd11, 27'd7000000, 32'd12, 32'd23, 32'd8, 32'd20, 32'd100);

    // Zero length acts as 1 ms
    settle();
    write_len(27'd0);
    push_bar(20'd3, 27'd100, 32'd1, 32'd2, 32'd0, 32'd1, 32'd1);
    push_bar(20'd3, 27'd100, 32'd1, 32'd3, 32'd0, 32'd1, 32'd1);
    push_bar(20'd3, 27'd101, 32'd1, 32'd2, 32'd0, 32'd1, 32'd1);

    // Length above a day acts as one day
    settle();
    write_len(27'h7FF_FFFF);
    push_bar(20'd3, DAY_MS - 1'b1, 32'd1, 32'd2, 32'd0, 32'd1, 32'd1);
    push_bar(20'd4, 27'd0, 32'd1, 32'd2, 32'd0, 32'd1, 32'd1);
    push_bar(20'd4, 27'h7FF_FFFF, 32'd1, 32'd2, 32'd0, 32'd1, 32'd1);

    // Random streams, one bar length per phase, some phases without stalls
    for (int p = 0; p < 8; p++) begin
      settle();
      calm = (p == 2 || p == 5);
      write_len(lens[p]);
      sim_day = 20'd100 + 20'(p);
      sim_ms  = 0;
      random_bars(115);
    end
    settle();

    if (sb.errors == 0) begin
      $display("tb_ohlc_bar_aggregator passed");
    end else begin
      $display("tb_ohlc_bar_aggregator failed");
    end
    $finish;
  end
endmodule

>>> filelist.f
+incdir+rtl
rtl/obar_pkg.sv
rtl/obar_front.sv
rtl/obar_queue.sv
rtl/obar_back.sv
rtl/ohlc_bar_aggregator.sv
tb/sv/tb_ohlc_bar_aggregator.sv
